### src/amrrs_pkg.sv
// ----------------------------------------------------------------------------
// amrrs_pkg
// Constants for the round-robin converter channel scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package amrrs_pkg;

  localparam int NumInputs = 8;
  localparam int SlotCount = 8;
  localparam int ChW       = 3;
  localparam int CntW      = ChW + 1;

  localparam int SeCount   = (NumInputs > SlotCount) ? SlotCount :
                             ((NumInputs < 2) ? 2 : NumInputs);
  localparam int DiffCount = (SeCount / 2 < 1) ? 1 : SeCount / 2;

  localparam int RawW      = 24;
  localparam int SignBit   = RawW - 1;

  // microvolts = sample * UvFull / CodeFull, CodeFull = 2^CodeShift - 1
  localparam int UvFull    = 2500000;
  localparam int UvW       = 22;
  localparam int CodeShift = 22;
  localparam int CodeFull  = (1 << CodeShift) - 1;
  localparam int ProdW     = RawW + UvW - 1;
  localparam int Q0W       = ProdW - CodeShift;
  localparam int R1W       = CodeShift + 2;
  localparam int R2W       = CodeShift + 1;

  localparam logic [7:0] SeNegCom = 8'h08;

endpackage

`default_nettype wire

### src/adc_mux_round_robin_scanner.sv
// ----------------------------------------------------------------------------
// adc_mux_round_robin_scanner
// Throughput: one word per cycle while out_stall is low; three register
// stages (input, product, result) lie between input word accept and result
// word valid, and each loads when the stage after it is empty or moving.
// Reset: rst clears the channel, scan mode and all stage valids.
// Mode write sets the channel back to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_mux_round_robin_scanner
  import amrrs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write_en,
  input  wire logic                     cfg_write_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [RawW-1:0]          raw_conversion,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [7:0]                    mux_code,
  output logic [ChW-1:0]                stored_slot,
  output logic signed [RawW-1:0]        sample_value,
  output logic signed [RawW-1:0]        microvolts,
  output logic                          sweep_done
);

  typedef struct packed {
    logic [7:0]     mux;
    logic [ChW-1:0] slot;
    logic           done;
  } tag_t;

  logic            scan_mode;
  logic [ChW-1:0]  channel;
  logic [ChW-1:0]  channel_next;

  logic            s1_valid;
  tag_t            s1_tag;
  logic [RawW-1:0] s1_raw;

  logic            s2_valid;
  tag_t            s2_tag;
  logic [RawW-1:0] s2_raw;
  logic [ProdW-1:0] s2_prod;

  logic            o_ready;
  logic            s2_ready;
  logic            s1_ready;
  logic            in_fire;

  logic [CntW-1:0] count;
  logic [CntW-1:0] ch_inc;
  logic            wrap;
  tag_t            tag_next;

  logic [RawW-1:0] mag;
  logic [ProdW-1:0] prod_next;

  logic [Q0W-1:0]  q0;
  logic [R1W-1:0]  r1;
  logic [R2W-1:0]  r2;
  logic [RawW-1:0] quot;
  logic [RawW-1:0] uv_next;

  assign o_ready  = !out_valid || !out_stall;
  assign s2_ready = !s2_valid || o_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;
  assign in_fire  = in_valid && s1_ready;

  // channel sequencing
  always_comb begin
    count  = scan_mode ? CntW'(DiffCount) : CntW'(SeCount);
    ch_inc = {1'b0, channel} + CntW'(1);
    wrap   = ch_inc >= count;
    channel_next = wrap ? '0 : ch_inc[ChW-1:0];
    if (scan_mode) begin
      tag_next.mux = {1'b0, channel[1:0], 1'b0, 1'b0, channel[1:0], 1'b1};
    end else begin
      tag_next.mux = {1'b0, channel, 4'b0000} | SeNegCom;
    end
    if (channel == '0) begin
      tag_next.slot = ChW'(count - CntW'(1));
    end else begin
      tag_next.slot = channel - ChW'(1);
    end
    tag_next.done = wrap && scan_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= 1'b0;
      channel   <= '0;
    end else if (cfg_write_en) begin
      scan_mode <= cfg_write_data;
      channel   <= '0;
    end else if (in_fire) begin
      channel   <= channel_next;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_tag <= tag_next;
      s1_raw <= raw_conversion;
    end
  end

  // magnitude times full-scale microvolts
  always_comb begin
    mag       = s1_raw[SignBit] ? (~s1_raw + RawW'(1)) : s1_raw;
    prod_next = ProdW'(mag) * ProdW'(UvFull);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_tag  <= s1_tag;
      s2_raw  <= s1_raw;
      s2_prod <= prod_next;
    end
  end

  // divide by 2^22-1: fold high part back into low part, then correct
  always_comb begin
    q0   = s2_prod[ProdW-1:CodeShift];
    r1   = R1W'(s2_prod[CodeShift-1:0]) + R1W'(q0);
    r2   = R2W'(r1[CodeShift-1:0]) + R2W'(r1[R1W-1:CodeShift]);
    quot = RawW'(q0) + RawW'(r1[R1W-1:CodeShift]) + RawW'(r2 >= R2W'(CodeFull));
    uv_next = s2_raw[SignBit] ? (~quot + RawW'(1)) : quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && s2_valid) begin
      mux_code     <= s2_tag.mux;
      stored_slot  <= s2_tag.slot;
      sweep_done   <= s2_tag.done;
      sample_value <= s2_raw;
      microvolts   <= uv_next;
    end
  end

endmodule

`default_nettype wire
